[rtl/core/npt_pkg.sv]
// ----------------------------------------------------------------------------
// npt_pkg
// Shared widths, request kinds and the controller/datapath command and
// status groups for the nearest point table.
// ----------------------------------------------------------------------------
package npt_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int COORD_W     = 16;
   localparam int MAG_W       = 16;
   localparam int SQ_W        = 2 * MAG_W;
   localparam int SLOT_W      = 10;
   localparam int DIST_W      = 34;
   localparam int ENTRY_W     = 3 * COORD_W + 1;

   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_QUERY  = 2'd2,
      KIND_CLEAR  = 2'd3
   } npt_kind_type;

   typedef struct packed {
      logic capture;       // take the request fields
      logic scan_start;    // rewind address, forget best and free slot
      logic scan_issue;    // read entry at address and advance
      logic sweep_write;   // write an empty entry at address and advance
      logic commit_write;  // store the added point or drop the deleted entry
      logic load_rsp;      // load the response register
   } npt_cmd_type;

   typedef struct packed {
      npt_kind_type kind;
      logic         addr_last;
      logic         pipe_busy;
      logic         out_free;
   } npt_sts_type;

endpackage

[rtl/core/npt_if.sv]
// ----------------------------------------------------------------------------
// npt_if
// Request and response channels of the nearest point table.
// ----------------------------------------------------------------------------
interface npt_req_if;
   import npt_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [1:0]                kind;
   logic signed [COORD_W-1:0] pos_x;
   logic signed [COORD_W-1:0] pos_y;
   logic signed [COORD_W-1:0] pos_z;

   modport source (output valid, kind, pos_x, pos_y, pos_z, input ready);
   modport sink   (input valid, kind, pos_x, pos_y, pos_z, output ready);
endinterface

interface npt_rsp_if;
   import npt_pkg::*;

   logic              valid;
   logic              ready;
   logic              found;
   logic [SLOT_W-1:0] slot;
   logic [DIST_W-1:0] best_distance;

   modport source (output valid, found, slot, best_distance, input ready);
   modport sink   (input valid, found, slot, best_distance, output ready);
endinterface

[rtl/core/npt_datapath.sv]
// ----------------------------------------------------------------------------
// npt_datapath
// Entry memory, scan address, distance pipeline, best and free-slot
// trackers and the response register.
// ----------------------------------------------------------------------------
module npt_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  npt_pkg::npt_cmd_type               cmd,
   output npt_pkg::npt_sts_type               sts,
   input  logic [1:0]                         req_kind,
   input  logic signed [npt_pkg::COORD_W-1:0] req_pos_x,
   input  logic signed [npt_pkg::COORD_W-1:0] req_pos_y,
   input  logic signed [npt_pkg::COORD_W-1:0] req_pos_z,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic                               rsp_found,
   output logic [npt_pkg::SLOT_W-1:0]         rsp_slot,
   output logic [npt_pkg::DIST_W-1:0]         rsp_best_distance
);
   import npt_pkg::*;

   localparam int VB = ENTRY_W - 1;

   function automatic logic [MAG_W-1:0] abs_diff(logic signed [COORD_W-1:0] a,
                                                  logic signed [COORD_W-1:0] b);
      logic signed [COORD_W:0] d;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      return d[COORD_W] ? MAG_W'(-d) : MAG_W'(d);
   endfunction

   // captured request
   npt_kind_type              kind_ff;
   logic signed [COORD_W-1:0] px_ff, py_ff, pz_ff;

   // scan address
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic             addr_last;

   // entry memory: valid bit on top, then x, y, z
   logic [ENTRY_W-1:0] mem_ff [TABLE_DEPTH];
   logic [ENTRY_W-1:0] rd_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;

   // distance pipeline
   logic             s1_go_ff, s2_go_ff, s3_go_ff, s4_go_ff;
   logic [IDX_W-1:0] s1_idx_ff, s2_idx_ff, s3_idx_ff, s4_idx_ff;
   logic             s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic [MAG_W-1:0] mx_ff, my_ff, mz_ff;
   logic [SQ_W-1:0]  sx_ff, sy_ff, sz_ff;
   logic [DIST_W-1:0] sum_ff;

   // trackers
   logic              best_any_ff, best_take;
   logic [DIST_W-1:0] best_d_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   logic              free_found_ff, free_take;
   logic [IDX_W-1:0]  free_idx_ff;
   logic [IDX_W-1:0]  target;

   // response
   logic              rsp_valid_ff;
   logic              found_ff, found_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [DIST_W-1:0] dist_ff, dist_in;

   // ---------------------------------------------------------------- request
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_ADD;
      end else if (cmd.capture) begin
         kind_ff <= npt_kind_type'(req_kind);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         px_ff <= req_pos_x;
         py_ff <= req_pos_y;
         pz_ff <= req_pos_z;
      end
   end

   // ---------------------------------------------------------------- address
   assign addr_last = (addr_ff == IDX_W'(TABLE_DEPTH - 1));

   always_comb begin
      addr_in = addr_ff;
      if (cmd.scan_start) begin
         addr_in = '0;
      end else if (cmd.scan_issue || cmd.sweep_write) begin
         addr_in = addr_last ? '0 : addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
      end else begin
         addr_ff <= addr_in;
      end
   end

   // ---------------------------------------------------------------- memory
   assign target = free_found_ff ? free_idx_ff : IDX_W'(TABLE_DEPTH - 1);

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = '0;
      if (cmd.sweep_write) begin
         mem_we = 1'b1;
      end else if (cmd.commit_write) begin
         if (kind_ff == KIND_ADD) begin
            mem_we    = 1'b1;
            mem_waddr = target;
            mem_wdata = {1'b1, px_ff, py_ff, pz_ff};
         end else if (kind_ff == KIND_DELETE && best_any_ff) begin
            mem_we    = 1'b1;
            mem_waddr = best_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      if (cmd.scan_issue) begin
         rd_ff <= mem_ff[addr_ff];
      end
   end

   // ---------------------------------------------------------------- pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_go_ff <= 1'b0;
         s2_go_ff <= 1'b0;
         s3_go_ff <= 1'b0;
         s4_go_ff <= 1'b0;
      end else begin
         s1_go_ff <= cmd.scan_issue;
         s2_go_ff <= s1_go_ff;
         s3_go_ff <= s2_go_ff;
         s4_go_ff <= s3_go_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff <= addr_ff;
      s2_idx_ff <= s1_idx_ff;
      s3_idx_ff <= s2_idx_ff;
      s4_idx_ff <= s3_idx_ff;
      s2_vld_ff <= rd_ff[VB];
      s3_vld_ff <= s2_vld_ff;
      s4_vld_ff <= s3_vld_ff;
      mx_ff     <= abs_diff(px_ff, rd_ff[3*COORD_W-1:2*COORD_W]);
      my_ff     <= abs_diff(py_ff, rd_ff[2*COORD_W-1:COORD_W]);
      mz_ff     <= abs_diff(pz_ff, rd_ff[COORD_W-1:0]);
      sx_ff     <= SQ_W'(mx_ff) * SQ_W'(mx_ff);
      sy_ff     <= SQ_W'(my_ff) * SQ_W'(my_ff);
      sz_ff     <= SQ_W'(mz_ff) * SQ_W'(mz_ff);
      sum_ff    <= DIST_W'(sx_ff) + DIST_W'(sy_ff) + DIST_W'(sz_ff);
   end

   // ---------------------------------------------------------------- trackers
   // strict compare: the scan runs upwards, so a tie keeps the lower index
   assign best_take = s4_go_ff && s4_vld_ff && (!best_any_ff || sum_ff < best_d_ff);
   assign free_take = s1_go_ff && !rd_ff[VB] && !free_found_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.scan_start) begin
         best_any_ff   <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         if (best_take) begin
            best_any_ff <= 1'b1;
         end
         if (free_take) begin
            free_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (best_take) begin
         best_d_ff   <= sum_ff;
         best_idx_ff <= s4_idx_ff;
      end
      if (free_take) begin
         free_idx_ff <= s1_idx_ff;
      end
   end

   // ---------------------------------------------------------------- response
   always_comb begin
      found_in = 1'b0;
      slot_in  = '0;
      dist_in  = '0;
      case (kind_ff)
         KIND_ADD: begin
            found_in = 1'b1;
            slot_in  = SLOT_W'(target);
         end
         KIND_DELETE, KIND_QUERY: begin
            if (best_any_ff) begin
               found_in = 1'b1;
               slot_in  = SLOT_W'(best_idx_ff);
               dist_in  = best_d_ff;
            end
         end
         default: begin
            found_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         found_ff <= found_in;
         slot_ff  <= slot_in;
         dist_ff  <= dist_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = found_ff;
   assign rsp_slot          = slot_ff;
   assign rsp_best_distance = dist_ff;

   assign sts.kind      = kind_ff;
   assign sts.addr_last = addr_last;
   assign sts.pipe_busy = s1_go_ff | s2_go_ff | s3_go_ff | s4_go_ff;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

endmodule

[rtl/core/npt_ctrl.sv]
// ----------------------------------------------------------------------------
// npt_ctrl
// Sequencer for the nearest point table: clearing sweep, scan, drain,
// write-back and response hand-off.
// ----------------------------------------------------------------------------
module npt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_kind,
   output logic                 req_ready,
   input  npt_pkg::npt_sts_type sts,
   output npt_pkg::npt_cmd_type cmd
);
   import npt_pkg::*;

   typedef enum logic [5:0] {
      ST_CLEAR   = 6'b000001,
      ST_IDLE    = 6'b000010,
      ST_SCAN    = 6'b000100,
      ST_DRAIN   = 6'b001000,
      ST_WRITE   = 6'b010000,
      ST_RESPOND = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      pending_ff, pending_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in   = state_ff;
      pending_in = pending_ff;
      cmd        = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.sweep_write = 1'b1;
            if (sts.addr_last) begin
               state_in = pending_ff ? ST_RESPOND : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.capture    = 1'b1;
               cmd.scan_start = 1'b1;
               pending_in     = 1'b1;
               state_in       = (npt_kind_type'(req_kind) == KIND_CLEAR) ? ST_CLEAR : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (sts.addr_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // hold until the last entry has been compared
            if (!sts.pipe_busy) begin
               state_in = (sts.kind inside {KIND_ADD, KIND_DELETE}) ? ST_WRITE : ST_RESPOND;
            end
         end
         ST_WRITE: begin
            cmd.commit_write = 1'b1;
            state_in         = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (sts.out_free) begin
               cmd.load_rsp = 1'b1;
               pending_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         pending_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pending_ff <= pending_in;
      end
   end

endmodule

[rtl/core/nearest_point_table.sv]
// ----------------------------------------------------------------------------
// nearest_point_table
// Add and delete scan the table, drain the distance pipeline, write back and
// respond; a query scans, drains and responds; a clear sweeps, then responds.
// One request is in service at a time; the next is taken once the response
// is loaded. The scan reads one entry a cycle from one memory.
// After reset a sweep empties the table; ready stays low.
// ----------------------------------------------------------------------------
module nearest_point_table (
   input logic        clock,
   input logic        reset,
   npt_req_if.sink    req,
   npt_rsp_if.source  rsp
);
   import npt_pkg::*;

   npt_cmd_type cmd;
   npt_sts_type sts;

   npt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_kind  (req.kind),
      .req_ready (req.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   npt_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_kind          (req.kind),
      .req_pos_x         (req.pos_x),
      .req_pos_y         (req.pos_y),
      .req_pos_z         (req.pos_z),
      .rsp_ready         (rsp.ready),
      .rsp_valid         (rsp.valid),
      .rsp_found         (rsp.found),
      .rsp_slot          (rsp.slot),
      .rsp_best_distance (rsp.best_distance)
   );

endmodule

[verif/tb_nearest_point_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_point_table
// Self-checking bench for the nearest point table. Requests go in through
// the request channel; a local copy of the point store predicts every
// response, and a checker process compares each response field by field.
// Covers the empty store, coordinate extremes, ties, a full store, a long
// response hold-off and a long random mix under several idling patterns.
// ----------------------------------------------------------------------------
module tb_nearest_point_table;
   import npt_pkg::*;

   localparam int                 RANDOM_PER_PHASE = 145;
   localparam int                 HOLD_CYCLES      = 3000;
   localparam int                 WATCHDOG_LIMIT   = 20000;
   localparam int                 DRAIN_CYCLES     = TABLE_DEPTH + 64;
   localparam logic signed [15:0] COORD_MAX        = 16'sh7FFF;
   localparam logic signed [15:0] COORD_MIN        = 16'sh8000;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] slot;
      logic [DIST_W-1:0] distance;
   } npt_result_type;

   logic clock = 1'b0;
   logic reset;

   npt_req_if req_ch ();
   npt_rsp_if rsp_ch ();

   nearest_point_table dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // local copy of the point store
   logic signed [15:0] point_x [TABLE_DEPTH];
   logic signed [15:0] point_y [TABLE_DEPTH];
   logic signed [15:0] point_z [TABLE_DEPTH];
   bit                 point_used [TABLE_DEPTH];
   int                 high_water;

   npt_result_type expected_results [$];

   int  idle_pct;
   int  stall_pct;
   bit  hold_request;
   int  error_count;
   int  responses_checked;
   int  found_count;
   int  kind_count [4];

   function automatic void note_failure(string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("[%0t] ERROR: %s", $realtime, msg);
      end
   endfunction

   function automatic npt_result_type predict_request(npt_kind_type kind,
                                                      logic signed [15:0] x,
                                                      logic signed [15:0] y,
                                                      logic signed [15:0] z);
      npt_result_type res;
      int             target;
      bit             hit;
      int             best_slot;
      longint         best_dist;
      longint         dx;
      longint         dy;
      longint         dz;
      longint         d;
      res.found    = 1'b0;
      res.slot     = '0;
      res.distance = '0;
      case (kind)
         KIND_ADD: begin
            // lowest free slot, else overwrite the last one
            target = TABLE_DEPTH - 1;
            for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
               if (!point_used[i]) target = i;
            end
            point_x[target]    = x;
            point_y[target]    = y;
            point_z[target]    = z;
            point_used[target] = 1'b1;
            if (target + 1 > high_water) high_water = target + 1;
            res.found = 1'b1;
            res.slot  = SLOT_W'(target);
         end
         KIND_DELETE, KIND_QUERY: begin
            hit       = 1'b0;
            best_slot = 0;
            best_dist = 0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (point_used[i]) begin
                  dx = longint'(x) - longint'(point_x[i]);
                  dy = longint'(y) - longint'(point_y[i]);
                  dz = longint'(z) - longint'(point_z[i]);
                  d  = dx * dx + dy * dy + dz * dz;
                  // strict less-than keeps the lower index on a tie
                  if (!hit || d < best_dist) begin
                     hit       = 1'b1;
                     best_dist = d;
                     best_slot = i;
                  end
               end
            end
            if (hit) begin
               if (kind == KIND_DELETE) point_used[best_slot] = 1'b0;
               res.found    = 1'b1;
               res.slot     = SLOT_W'(best_slot);
               res.distance = DIST_W'(best_dist);
            end
         end
         default: begin
            foreach (point_used[i]) point_used[i] = 1'b0;
         end
      endcase
      return res;
   endfunction

   function automatic logic signed [15:0] pick_coord();
      case ($urandom_range(9))
         0:       return COORD_MAX;
         1:       return COORD_MIN;
         2, 3, 4: return 16'($urandom_range(8)) - 16'sd4;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_request(input npt_kind_type kind, input logic signed [15:0] x,
                               input logic signed [15:0] y, input logic signed [15:0] z);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind  <= kind;
      req_ch.pos_x <= x;
      req_ch.pos_y <= y;
      req_ch.pos_z <= z;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      expected_results.push_back(predict_request(kind, x, y, z));
      kind_count[int'(kind)]++;
   endtask

   task automatic test_empty_store();
      send_request(KIND_QUERY, 16'sd0, 16'sd0, 16'sd0);
      send_request(KIND_DELETE, COORD_MAX, COORD_MIN, 16'sd0);
      send_request(KIND_CLEAR, 16'sd0, 16'sd0, 16'sd0);
      send_request(KIND_QUERY, COORD_MIN, COORD_MIN, COORD_MIN);
   endtask

   task automatic test_directed();
      send_request(KIND_ADD, COORD_MAX, COORD_MAX, COORD_MAX);
      // opposite corners give the largest possible distance
      send_request(KIND_QUERY, COORD_MIN, COORD_MIN, COORD_MIN);
      send_request(KIND_ADD, COORD_MIN, COORD_MIN, COORD_MIN);
      send_request(KIND_ADD, 16'sd0, 16'sd0, 16'sd0);
      send_request(KIND_ADD, 16'sd0, 16'sd0, 16'sd0);
      send_request(KIND_QUERY, 16'sd1, 16'sd0, 16'sd0);
      send_request(KIND_DELETE, 16'sd0, 16'sd0, -16'sd1);
      send_request(KIND_QUERY, 16'sd0, 16'sd0, 16'sd0);
      send_request(KIND_ADD, 16'sd5, -16'sd5, 16'sd5);
      send_request(KIND_ADD, COORD_MAX, COORD_MIN, COORD_MAX);
      send_request(KIND_QUERY, COORD_MAX, COORD_MIN, 16'sd0);
      send_request(KIND_DELETE, COORD_MIN, COORD_MAX, COORD_MIN);
      send_request(KIND_QUERY, COORD_MIN, COORD_MIN, COORD_MIN);
      send_request(KIND_ADD, -16'sd1, -16'sd1, -16'sd1);
      send_request(KIND_CLEAR, COORD_MAX, COORD_MAX, COORD_MAX);
      send_request(KIND_QUERY, 16'sd0, 16'sd0, 16'sd0);
      send_request(KIND_ADD, 16'sd3, 16'sd2, 16'sd1);
      send_request(KIND_DELETE, 16'sd3, 16'sd2, 16'sd1);
      send_request(KIND_DELETE, 16'sd3, 16'sd2, 16'sd1);
   endtask

   task automatic test_full_store();
      send_request(KIND_CLEAR, 16'sd0, 16'sd0, 16'sd0);
      for (int n = 0; n < TABLE_DEPTH; n++) begin
         send_request(KIND_ADD, pick_coord(), pick_coord(), pick_coord());
      end
      // store full: the last slot is overwritten
      send_request(KIND_ADD, COORD_MIN, COORD_MAX, COORD_MIN);
      send_request(KIND_ADD, 16'sd7, 16'sd7, 16'sd7);
      send_request(KIND_QUERY, 16'sd7, 16'sd7, 16'sd7);
      send_request(KIND_DELETE, point_x[100], point_y[100], point_z[100]);
      send_request(KIND_ADD, COORD_MAX, 16'sd0, COORD_MIN);
      send_request(KIND_QUERY, COORD_MAX, 16'sd0, COORD_MIN);
      send_request(KIND_CLEAR, 16'sd0, 16'sd0, 16'sd0);
   endtask

   task automatic test_response_hold_off();
      idle_pct     = 0;
      stall_pct    = 0;
      hold_request = 1'b1;
      send_request(KIND_ADD, 16'sd10, 16'sd20, 16'sd30);
      send_request(KIND_QUERY, 16'sd11, 16'sd19, 16'sd30);
      send_request(KIND_DELETE, 16'sd10, 16'sd20, 16'sd31);
      send_request(KIND_QUERY, 16'sd0, 16'sd0, 16'sd0);
   endtask

   task automatic test_random_mix();
      int                 phase_idle [4] = '{0, 82, 0, 10};
      int                 phase_stall [4] = '{0, 0, 82, 10};
      int                 pick;
      int                 src;
      npt_kind_type       kind;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      for (int p = 0; p < 4; p++) begin
         idle_pct  = phase_idle[p];
         stall_pct = phase_stall[p];
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            pick = $urandom_range(99);
            if (pick < 40)      kind = KIND_ADD;
            else if (pick < 60) kind = KIND_DELETE;
            else if (pick < 97) kind = KIND_QUERY;
            else                kind = KIND_CLEAR;
            x = pick_coord();
            y = pick_coord();
            z = pick_coord();
            // search near a stored point now and then to provoke close calls
            if (kind != KIND_ADD && high_water > 0 && $urandom_range(2) == 0) begin
               src = $urandom_range(high_water - 1);
               x   = point_x[src] + 16'($urandom_range(2)) - 16'sd1;
               y   = point_y[src];
               z   = point_z[src] + 16'($urandom_range(2)) - 16'sd1;
            end
            send_request(kind, x, y, z);
         end
      end
   endtask

   initial begin : response_checker
      npt_result_type want;
      int             hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (expected_results.size() == 0) begin
               note_failure("response with no request outstanding");
            end else begin
               want = expected_results.pop_front();
               responses_checked++;
               if (want.found) found_count++;
               if (rsp_ch.found !== want.found || rsp_ch.slot !== want.slot ||
                   rsp_ch.best_distance !== want.distance) begin
                  note_failure($sformatf(
                     "mismatch: found %0b/%0b slot %0d/%0d distance %0d/%0d (exp/act)",
                     want.found, rsp_ch.found, want.slot, rsp_ch.slot,
                     want.distance, rsp_ch.best_distance));
               end
            end
         end
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] ERROR: no handshake for %0d cycles", $realtime, quiet_cycles);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.kind  <= KIND_ADD;
      req_ch.pos_x <= '0;
      req_ch.pos_y <= '0;
      req_ch.pos_z <= '0;
      idle_pct     = 0;
      stall_pct    = 0;
      hold_request = 1'b0;
      high_water   = 0;
      foreach (point_used[i]) begin
         point_used[i] = 1'b0;
         point_x[i]    = '0;
         point_y[i]    = '0;
         point_z[i]    = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_store();
      test_directed();
      test_full_store();
      test_response_hold_off();
      test_random_mix();

      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) note_failure("responses still outstanding at end");

      $display("Covered %0d adds, %0d deletes, %0d queries, %0d clears, full store included.",
               kind_count[KIND_ADD], kind_count[KIND_DELETE], kind_count[KIND_QUERY],
               kind_count[KIND_CLEAR]);
      $display("Checked %0d responses (%0d with a hit), %0d errors.",
               responses_checked, found_count, error_count);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
